@@ design/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Status codes and result field widths used by the top level and interfaces.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int ROOT_WIDTH   = 34;
    localparam int STATUS_WIDTH = 2;

    // Result status of one item
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_REAL     = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_A_ZERO   = 2'd2
    } status_t;

endpackage

@@ design/qrs_in_if.sv @@
// ----------------------------------------------------------------------------
// qrs_in_if: coefficient channel
// Valid/ready channel carrying one coefficient triple per item.
// ----------------------------------------------------------------------------
interface qrs_in_if #(
    parameter int COEF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

@@ design/qrs_out_if.sv @@
// ----------------------------------------------------------------------------
// qrs_out_if: root channel
// Valid/ready channel carrying both roots and the status per item.
// ----------------------------------------------------------------------------
interface qrs_out_if
    import qrs_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [ROOT_WIDTH-1:0] root_plus;
    logic signed [ROOT_WIDTH-1:0] root_minus;
    logic [STATUS_WIDTH-1:0]      solve_status;

    modport source (output valid, output root_plus, output root_minus,
                    output solve_status, input ready);
    modport sink   (input valid, input root_plus, input root_minus,
                    input solve_status, output ready);
endinterface

@@ design/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the pipelined square root
// Restoring radix-4 step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int QW     = 33,
    parameter int SIDE_W = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2*QW-1:0]     x_in,
    input  logic [QW+1:0]       r_in,
    input  logic [QW-1:0]       q_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2*QW-1:0]     x_out,
    output logic [QW+1:0]       r_out,
    output logic [QW-1:0]       q_out,
    output logic [SIDE_W-1:0]   side_out
);
    localparam int RW = QW + 2;

    logic              valid_reg;
    logic [2*QW-1:0]   x_reg;
    logic [RW-1:0]     r_reg, r_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [SIDE_W-1:0] side_reg;
    logic [RW-1:0]     shifted;
    logic [RW-1:0]     trial;
    logic              fits;

    // One trial subtraction
    always_comb
    begin
        shifted = {r_in[RW-3:0], x_in[2*QW-1 -: 2]};
        trial   = {q_in, 2'b01};
        fits    = (shifted >= trial);
        r_next  = fits ? (shifted - trial) : shifted;
        q_next  = {q_in[QW-2:0], fits};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= {x_in[2*QW-3:0], 2'b00};
            r_reg    <= r_next;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign r_out     = r_reg;
    assign q_out     = q_reg;
    assign side_out  = side_reg;
endmodule

@@ design/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of the pipelined dual divider
// Restoring step on two numerators sharing one divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int NW     = 34,
    parameter int DV     = 17,
    parameter int SIDE_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NW-1:0]     n_in [2],
    input  logic [DV-1:0]     r_in [2],
    input  logic [NW-1:0]     q_in [2],
    input  logic [DV-1:0]     d_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NW-1:0]     n_out [2],
    output logic [DV-1:0]     r_out [2],
    output logic [NW-1:0]     q_out [2],
    output logic [DV-1:0]     d_out,
    output logic [SIDE_W-1:0] side_out
);
    logic              valid_reg;
    logic [NW-1:0]     n_reg [2];
    logic [DV-1:0]     r_reg [2];
    logic [DV-1:0]     r_next [2];
    logic [NW-1:0]     q_reg [2];
    logic [NW-1:0]     q_next [2];
    logic [DV-1:0]     d_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DV:0]       shifted [2];
    logic [DV:0]       diff [2];
    logic              fits [2];

    // Both lanes: shift in next numerator bit, subtract if it fits
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            shifted[k] = {r_in[k], n_in[k][NW-1]};
            diff[k]    = shifted[k] - {1'b0, d_in};
            fits[k]    = (shifted[k] >= {1'b0, d_in});
            r_next[k]  = fits[k] ? diff[k][DV-1:0] : shifted[k][DV-1:0];
            q_next[k]  = {q_in[k][NW-2:0], fits[k]};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int k = 0; k < 2; k++)
            begin
                n_reg[k] <= {n_in[k][NW-2:0], 1'b0};
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
            end
            d_reg    <= d_in;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign n_out     = n_reg;
    assign r_out     = r_reg;
    assign q_out     = q_reg;
    assign d_out     = d_reg;
    assign side_out  = side_reg;
endmodule

@@ design/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c
// Pipelined discriminant, digit-per-cell square root and dual divider.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  coef_ch  | in  | coef_a, coef_b, coef_c (signed, COEF_WIDTH)
//  root_ch  | out | root_plus, root_minus (signed, 34b, FRAC_BITS frac), solve_status
//
// One item per cycle while root_ch is not stalled. Registers in order: stages 1 to 3,
// (COEF_WIDTH+FRAC_BITS+1) square root cells, stage 4, (COEF_WIDTH+FRAC_BITS+2)
// divider cells and stage 5.
// Reset clears only the valid bits. Every stage moves when it is empty or
// its successor moves, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qrs_in_if.sink     coef_ch,
    qrs_out_if.source  root_ch
);
    localparam int CW    = COEF_WIDTH;
    localparam int DW    = 2 * CW + 2;
    localparam int QW    = CW + 1 + FRAC_BITS;
    localparam int NW    = QW + 1;
    localparam int DV    = CW + 1;
    localparam int SQ_SW = STATUS_WIDTH + 2 * CW + 2;
    localparam int DV_SW = STATUS_WIDTH + 1;

    // ---------------- stage 1: input register ----------------
    logic          s1_valid_reg;
    logic [CW-1:0] a_raw_reg, b_raw_reg, c_raw_reg;
    logic          s1_ready, s2_ready, s3_ready;

    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign coef_ch.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= coef_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && coef_ch.valid)
        begin
            a_raw_reg <= coef_ch.coef_a;
            b_raw_reg <= coef_ch.coef_b;
            c_raw_reg <= coef_ch.coef_c;
        end
    end

    // ---------------- stage 2: magnitudes and products ----------------
    logic            s2_valid_reg;
    logic [CW-1:0]   am_next, bm_next, cm_next;
    logic [CW-1:0]   am_reg, bm_reg;
    logic            an_reg, bn_reg, cn_reg;
    logic [2*CW-1:0] bb_reg, ac_reg;

    always_comb
    begin
        am_next = a_raw_reg[CW-1] ? (~a_raw_reg + 1'b1) : a_raw_reg;
        bm_next = b_raw_reg[CW-1] ? (~b_raw_reg + 1'b1) : b_raw_reg;
        cm_next = c_raw_reg[CW-1] ? (~c_raw_reg + 1'b1) : c_raw_reg;
    end

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            am_reg <= am_next;
            bm_reg <= bm_next;
            an_reg <= a_raw_reg[CW-1];
            bn_reg <= b_raw_reg[CW-1];
            cn_reg <= c_raw_reg[CW-1];
            bb_reg <= bm_next * bm_next;
            ac_reg <= am_next * cm_next;
        end
    end

    // ---------------- stage 3: discriminant and status ----------------
    logic          s3_valid_reg;
    logic [DW-1:0] bb_ext, p_val, disc_next, disc_reg;
    status_t       st_next, st3_reg;
    logic [CW-1:0] am3_reg, bm3_reg;
    logic          an3_reg, bn3_reg;
    logic          sq_ready [QW+1];

    always_comb
    begin
        bb_ext    = DW'(bb_reg);
        p_val     = {ac_reg, 2'b00};
        st_next   = ST_REAL;
        disc_next = bb_ext - p_val;
        if (am_reg == '0)
        begin
            st_next = ST_A_ZERO;
        end
        else if (p_val != '0 && an_reg != cn_reg)
        begin
            disc_next = bb_ext + p_val;
        end
        else if (bb_ext < p_val)
        begin
            st_next = ST_NEG_DISC;
        end
    end

    assign s3_ready = !s3_valid_reg || sq_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            disc_reg <= disc_next;
            st3_reg  <= st_next;
            am3_reg  <= am_reg;
            bm3_reg  <= bm_reg;
            an3_reg  <= an_reg;
            bn3_reg  <= bn_reg;
        end
    end

    // ---------------- square root cell row ----------------
    logic             sq_valid [QW+1];
    logic [2*QW-1:0]  sq_x     [QW+1];
    logic [QW+1:0]    sq_r     [QW+1];
    logic [QW-1:0]    sq_q     [QW+1];
    logic [SQ_SW-1:0] sq_side  [QW+1];
    logic             s4_ready;

    assign sq_valid[0] = s3_valid_reg;
    assign sq_x[0]     = {disc_reg, {(2 * FRAC_BITS){1'b0}}};
    assign sq_r[0]     = '0;
    assign sq_q[0]     = '0;
    assign sq_side[0]  = {st3_reg, an3_reg, am3_reg, bn3_reg, bm3_reg};
    assign sq_ready[QW] = s4_ready;

    for (genvar i = 0; i < QW; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .QW     (QW),
            .SIDE_W (SQ_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .x_in      (sq_x[i]),
            .r_in      (sq_r[i]),
            .q_in      (sq_q[i]),
            .side_in   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .x_out     (sq_x[i+1]),
            .r_out     (sq_r[i+1]),
            .q_out     (sq_q[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // ---------------- stage 4: signed numerators ----------------
    logic [STATUS_WIDTH-1:0] st4_side;
    logic [CW-1:0]           am4, bm4;
    logic                    an4, bn4;
    logic [NW-1:0]           s_ext, bs_ext;
    logic [NW-1:0]           pm_next, mm_next;
    logic                    pneg_next, mneg_next;
    logic                    s4_valid_reg;
    logic [NW-1:0]           pm_reg, mm_reg;
    logic [DV-1:0]           d_reg;
    logic [DV_SW-1:0]        dv_side_reg;
    logic                    mneg_reg;
    logic                    dv_ready [NW+1];

    always_comb
    begin
        {st4_side, an4, am4, bn4, bm4} = sq_side[QW];
        s_ext  = NW'(sq_q[QW]);
        bs_ext = NW'({bm4, {FRAC_BITS{1'b0}}});
        // -b + s
        if (bm4 == '0 || bn4)
        begin
            pm_next = bs_ext + s_ext;
            pneg_next = 1'b0;
        end
        else if (s_ext >= bs_ext)
        begin
            pm_next = s_ext - bs_ext;
            pneg_next = 1'b0;
        end
        else
        begin
            pm_next = bs_ext - s_ext;
            pneg_next = 1'b1;
        end
        // -b - s
        if (bm4 != '0 && !bn4)
        begin
            mm_next = bs_ext + s_ext;
            mneg_next = 1'b1;
        end
        else if (bs_ext >= s_ext)
        begin
            mm_next = bs_ext - s_ext;
            mneg_next = 1'b0;
        end
        else
        begin
            mm_next = s_ext - bs_ext;
            mneg_next = 1'b1;
        end
    end

    assign s4_ready = !s4_valid_reg || dv_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            s4_valid_reg <= sq_valid[QW];
        end
    end

    // Result sign folds in the sign of a; plus-lane sign rides in the side bits
    always_ff @(posedge clk)
    begin
        if (s4_ready && sq_valid[QW])
        begin
            pm_reg      <= pm_next;
            mm_reg      <= mm_next;
            mneg_reg    <= mneg_next ^ an4;
            d_reg       <= {am4, 1'b0};
            dv_side_reg <= {st4_side, pneg_next ^ an4};
        end
    end

    // ---------------- divider cell row ----------------
    logic             dv_valid [NW+1];
    logic [NW-1:0]    dv_n     [NW+1][2];
    logic [DV-1:0]    dv_r     [NW+1][2];
    logic [NW-1:0]    dv_q     [NW+1][2];
    logic [DV-1:0]    dv_d     [NW+1];
    logic [DV_SW-1:0] dv_side  [NW+1];
    logic             s5_ready;

    assign dv_valid[0]   = s4_valid_reg;
    assign dv_n[0][0]    = pm_reg;
    assign dv_n[0][1]    = mm_reg;
    assign dv_r[0][0]    = '0;
    assign dv_r[0][1]    = '0;
    assign dv_q[0][0]    = '0;
    assign dv_q[0][1]    = '0;
    assign dv_d[0]       = d_reg;
    assign dv_side[0]    = dv_side_reg;
    assign dv_ready[NW]  = s5_ready;

    // Minus-lane sign rides alongside in its own pipe
    logic             mneg_pipe [NW+1];
    assign mneg_pipe[0] = mneg_reg;

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        qrs_div_cell #(
            .NW     (NW),
            .DV     (DV),
            .SIDE_W (DV_SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .n_in      (dv_n[j]),
            .r_in      (dv_r[j]),
            .q_in      (dv_q[j]),
            .d_in      (dv_d[j]),
            .side_in   (dv_side[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .n_out     (dv_n[j+1]),
            .r_out     (dv_r[j+1]),
            .q_out     (dv_q[j+1]),
            .d_out     (dv_d[j+1]),
            .side_out  (dv_side[j+1])
        );

        logic mneg_stage_reg;
        always_ff @(posedge clk)
        begin
            if (dv_ready[j] && dv_valid[j])
            begin
                mneg_stage_reg <= mneg_pipe[j];
            end
        end
        assign mneg_pipe[j+1] = mneg_stage_reg;
    end

    // ---------------- stage 5: output register ----------------
    logic                    s5_valid_reg;
    logic [ROOT_WIDTH-1:0]   qp_ext, qm_ext;
    logic [ROOT_WIDTH-1:0]   rp_next, rm_next;
    logic [STATUS_WIDTH-1:0] st5;
    logic [ROOT_WIDTH-1:0]   rp_reg, rm_reg;
    logic [STATUS_WIDTH-1:0] st_reg;

    always_comb
    begin
        st5    = dv_side[NW][DV_SW-1:1];
        qp_ext = ROOT_WIDTH'(dv_q[NW][0]);
        qm_ext = ROOT_WIDTH'(dv_q[NW][1]);
        rp_next = dv_side[NW][0] ? (~qp_ext + 1'b1) : qp_ext;
        rm_next = mneg_pipe[NW]  ? (~qm_ext + 1'b1) : qm_ext;
        if (st5 != ST_REAL)
        begin
            rp_next = '0;
            rm_next = '0;
        end
    end

    assign s5_ready = !s5_valid_reg || root_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            s5_valid_reg <= dv_valid[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && dv_valid[NW])
        begin
            rp_reg <= rp_next;
            rm_reg <= rm_next;
            st_reg <= st5;
        end
    end

    assign root_ch.valid        = s5_valid_reg;
    assign root_ch.root_plus    = rp_reg;
    assign root_ch.root_minus   = rm_reg;
    assign root_ch.solve_status = st_reg;
endmodule
